FILE: sv/lin_rx_pkg.sv
// shared types, constants and helpers for the lin slave frame receiver
`default_nettype none

package lin_rx_pkg;

	// frame shape
	localparam int SLOT_COUNT     = 4;
	localparam int MAX_DATA_BYTES = 8;

	// register file layout: four id registers, then four length registers
	localparam int          NUM_SLOT_REGS = 4;
	localparam logic [2:0]  CFG_LEN_BASE  = 3'd4;

	// byte codes on the bus
	localparam logic [7:0] BREAK_BYTE = 8'h00;
	localparam logic [7:0] SYNC_BYTE  = 8'h55;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// operation kinds handed from front to back
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [1:0] slot;
		logic [2:0] pos;
		logic [7:0] data;
		logic       ok;
	} lin_op_t;

	// one's complement byte add with end-around carry
	function automatic logic [7:0] carry_add(input logic [7:0] acc, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, acc} + {1'b0, b};
		if (s[8]) begin
			s = s - 9'd255;
		end
		return s[7:0];
	endfunction

endpackage

`default_nettype wire

FILE: sv/lin_rx_front.sv
// frame parser: config registers, phase machine, checksum, op generation
`default_nettype none

module lin_rx_front
	import lin_rx_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [7:0]    cfg_data,
	input  wire logic          in_fire,
	input  wire logic [7:0]    in_byte,
	output      logic          op_push,
	output      lin_op_t       op_out
);

	localparam logic [2:0] PH_BREAK = 3'd0;
	localparam logic [2:0] PH_SYNC  = 3'd1;
	localparam logic [2:0] PH_ID    = 3'd2;
	localparam logic [2:0] PH_DATA  = 3'd3;
	localparam logic [2:0] PH_CHECK = 3'd4;

	localparam logic [3:0] MAX_LEN = 4'(MAX_DATA_BYTES);

	logic [7:0] slot_id_q  [NUM_SLOT_REGS];
	logic [3:0] slot_len_q [NUM_SLOT_REGS];

	logic [2:0] phase_q;
	logic [1:0] slot_q;
	logic [3:0] count_q;
	logic [3:0] frame_len_q;
	logic [7:0] sum_q;

	logic       hit;
	logic [1:0] hit_slot;
	logic [3:0] len_sel;
	logic [3:0] count_nx;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOT_REGS; i++) begin
				slot_id_q[i]  <= 8'h00;
				slot_len_q[i] <= MAX_LEN;
			end
		end else if (cfg_we) begin
			if (cfg_index < CFG_LEN_BASE) begin
				slot_id_q[cfg_index[1:0]] <= cfg_data;
			end else begin
				slot_len_q[cfg_index[1:0]] <= cfg_data[3:0];
			end
		end
	end

	// id match, highest slot wins
	always_comb begin
		hit      = 1'b0;
		hit_slot = 2'd0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (in_byte == slot_id_q[i]) begin
				hit      = 1'b1;
				hit_slot = 2'(i);
			end
		end
	end

	// clamp the length register into the legal range
	always_comb begin
		len_sel = slot_len_q[hit_slot];
		if (len_sel == 4'd0) begin
			len_sel = 4'd1;
		end else if (len_sel > MAX_LEN) begin
			len_sel = MAX_LEN;
		end
	end

	assign count_nx = count_q + 4'd1;

	// phase machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_BREAK;
			slot_q      <= 2'd0;
			count_q     <= 4'd0;
			frame_len_q <= 4'd0;
			sum_q       <= 8'h00;
		end else if (in_fire) begin
			unique case (phase_q)
				PH_SYNC: begin
					phase_q <= (in_byte == SYNC_BYTE) ? PH_ID : PH_BREAK;
				end
				PH_ID: begin
					if (hit) begin
						slot_q      <= hit_slot;
						frame_len_q <= len_sel;
						count_q     <= 4'd0;
						sum_q       <= in_byte;
						phase_q     <= PH_DATA;
					end else begin
						phase_q <= PH_BREAK;
					end
				end
				PH_DATA: begin
					sum_q   <= carry_add(sum_q, in_byte);
					count_q <= count_nx;
					if (count_nx >= frame_len_q) begin
						phase_q <= PH_CHECK;
					end
				end
				PH_CHECK: begin
					phase_q <= PH_BREAK;
				end
				default: begin
					phase_q <= (in_byte == BREAK_BYTE) ? PH_SYNC : PH_BREAK;
				end
			endcase
		end
	end

	// ops for the back end: data byte stores and frame completion
	always_comb begin
		op_push      = in_fire && (phase_q == PH_DATA || phase_q == PH_CHECK);
		op_out.kind  = (phase_q == PH_CHECK) ? OP_FINISH : OP_WRITE;
		op_out.slot  = slot_q;
		op_out.pos   = count_q[2:0];
		op_out.data  = in_byte;
		op_out.ok    = (~sum_q == in_byte);
	end

endmodule

`default_nettype wire

FILE: sv/lin_rx_queue.sv
// small fifo of ops between the parser and the buffer stage
`default_nettype none

module lin_rx_queue
	import lin_rx_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire lin_op_t  push_op,
	output      logic     full,
	input  wire logic     pop,
	output      logic     empty,
	output      lin_op_t  head_op
);

	lin_op_t               mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_AW:0]     count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full    = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head_op = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/lin_rx_back.sv
// slot buffers and result register
`default_nettype none

module lin_rx_back
	import lin_rx_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          op_avail,
	input  wire lin_op_t       op_in,
	output      logic          op_pop,
	output      logic          out_valid,
	input  wire logic          out_ready,
	output      logic [63:0]   out_payload,
	output      logic [2:0]    out_user
);

	logic [63:0] buf_q [NUM_SLOT_REGS];
	logic        valid_q;
	logic [63:0] payload_q;
	logic [2:0]  user_q;
	logic        out_free;

	assign out_free    = !valid_q || out_ready;
	assign op_pop      = op_avail && (op_in.kind == OP_WRITE || out_free);
	assign out_valid   = valid_q;
	assign out_payload = payload_q;
	assign out_user    = user_q;

	// byte stores into the slot buffers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOT_REGS; i++) begin
				buf_q[i] <= 64'd0;
			end
		end else if (op_pop && op_in.kind == OP_WRITE) begin
			buf_q[op_in.slot][{op_in.pos, 3'b000} +: 8] <= op_in.data;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (op_pop && op_in.kind == OP_FINISH) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (op_pop && op_in.kind == OP_FINISH) begin
			payload_q <= buf_q[op_in.slot];
			user_q    <= {op_in.ok, op_in.slot};
		end
	end

endmodule

`default_nettype wire

FILE: sv/lin_slave_frame_receiver.sv
// top level of the lin slave frame receiver
//
// channel   | direction | contents
// s_axis    | in        | tdata[7:0] received byte
// m_axis    | out       | tdata[63:0] slot payload, tuser[1:0] slot, tuser[2] checksum ok
// cfg       | in        | write enable, index 0..7, 8-bit data
//
// one byte is taken every cycle while the op queue has room
// after its checksum byte a result is held first in the op queue, then in the result register
// the parser runs on while a result waits; only a full four-entry queue stalls input
// reset clears phase, slot buffers, queue and result valid flag asynchronously
`default_nettype none

module lin_slave_frame_receiver
	import lin_rx_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output      logic         s_axis_tready,
	input  wire logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
	output      logic         m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output      logic [63:0]  m_axis_tdata,   // [63:0] payload
	output      logic [2:0]   m_axis_tuser,   // [1:0] slot_index, [2] checksum_ok
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [7:0]   cfg_data
);

	logic    q_full;
	logic    q_empty;
	logic    in_fire;
	logic    op_push;
	logic    op_pop;
	lin_op_t op_new;
	lin_op_t op_head;

	assign s_axis_tready = !q_full;
	assign in_fire       = s_axis_tvalid && !q_full;

	// parser
	lin_rx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_fire   (in_fire),
		.in_byte   (s_axis_tdata),
		.op_push   (op_push),
		.op_out    (op_new)
	);

	// decoupling queue
	lin_rx_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (op_push),
		.push_op (op_new),
		.full    (q_full),
		.pop     (op_pop),
		.empty   (q_empty),
		.head_op (op_head)
	);

	// buffers and output
	lin_rx_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.op_avail    (!q_empty),
		.op_in       (op_head),
		.op_pop      (op_pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_payload (m_axis_tdata),
		.out_user    (m_axis_tuser)
	);

endmodule

`default_nettype wire

FILE: sv/lin_rx_checker.sv
// port-level checks for the lin slave frame receiver
`default_nettype none

module lin_rx_checker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	input  wire logic         s_axis_tready,
	input  wire logic         m_axis_tvalid,
	input  wire logic         m_axis_tready,
	input  wire logic [63:0]  m_axis_tdata,
	input  wire logic [2:0]   m_axis_tuser
);

	// a stalled result holds its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// no result once a reset cycle has gone by
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !m_axis_tvalid)
		else $error("result valid during reset");

	// the queue fills only through accepted bytes
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tready))
		else $error("input ready dropped without a transaction");

	// no result raised on the first cycle out of reset
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(arst_n))
		else $error("result raised straight out of reset");

endmodule

bind lin_slave_frame_receiver lin_rx_checker u_lin_rx_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
